// ===== sv/slpf_pkg.sv =====
`timescale 1ns / 1ps
// shared types, constants and lookup tables for the spectrum level / peak tracker
// no dependencies
package slpf_pkg;

   typedef struct packed {
      logic [15:0] level;
      logic [15:0] peak;
      logic [15:0] speed;
   } band_state_type;

   typedef struct packed {
      logic       display_mode;
      logic [2:0] level_sel;
      logic [2:0] peak_sel;
   } update_cfg_type;

   localparam int unsigned STATE_W = $bits(band_state_type);

   // settings register indexes
   localparam logic [1:0] CSR_DISPLAY_MODE = 2'd0;
   localparam logic [1:0] CSR_LEVEL_FALLOFF = 2'd1;
   localparam logic [1:0] CSR_PEAK_FALLOFF = 2'd2;
   localparam logic [1:0] CSR_REFRESH = 2'd3;

   // speed loaded when a new peak is captured, 3/256
   localparam logic [15:0] PEAK_SPEED_INIT = 16'd3;
   localparam logic [24:0] GAIN_ROUND = 25'd128;

   // level step per tick, Q8.8; selects above 4 act as 4
   function automatic logic [15:0] level_step(input logic [2:0] sel);
      logic [15:0] step;
      case (sel)
         3'd0: step = 16'd87;
         3'd1: step = 16'd128;
         3'd2: step = 16'd256;
         3'd3: step = 16'd333;
         default: step = 16'd410;
      endcase
      return step;
   endfunction

   // speed growth factor, Q.8
   function automatic logic [8:0] speed_gain(input logic [2:0] sel);
      logic [8:0] gain;
      case (sel)
         3'd0: gain = 9'd307;
         3'd1: gain = 9'd333;
         3'd2: gain = 9'd358;
         3'd3: gain = 9'd384;
         default: gain = 9'd410;
      endcase
      return gain;
   endfunction

   // redraw interval in ticks
   function automatic logic [3:0] redraw_interval(input logic [1:0] sel);
      logic [3:0] ival;
      case (sel)
         2'd0: ival = 4'd1;
         2'd1: ival = 4'd2;
         2'd2: ival = 4'd4;
         default: ival = 4'd8;
      endcase
      return ival;
   endfunction

endpackage

// ===== sv/slpf_update.sv =====
`timescale 1ns / 1ps
// per-band level / peak / speed update, combinational
// depends on slpf_pkg
module slpf_update (
   input  slpf_pkg::update_cfg_type cfg,
   input  slpf_pkg::band_state_type cur,
   input  logic [7:0]               sample,
   input  logic                     sample_valid,
   input  logic                     tick,
   output slpf_pkg::band_state_type nxt
);
   import slpf_pkg::*;

   logic [15:0] smp16;
   logic [15:0] step;
   logic [15:0] lv_new;
   logic [15:0] peak_dec;
   logic [24:0] prod;
   logic [24:0] prod_rnd;
   logic [16:0] grown;
   logic [15:0] speed_sat;
   logic        do_decay;

   assign smp16    = {sample, 8'h00};
   assign step     = level_step(cfg.level_sel);
   assign peak_dec = (cur.peak > cur.speed) ? cur.peak - cur.speed : 16'd0;
   assign prod     = 25'(cur.speed) * 25'(speed_gain(cfg.peak_sel));
   assign prod_rnd = prod + GAIN_ROUND;
   assign grown    = prod_rnd[24:8];
   assign speed_sat = grown[16] ? 16'hFFFF : grown[15:0];

   always_comb begin
      nxt      = cur;
      lv_new   = cur.level;
      do_decay = 1'b0;
      if (!cfg.display_mode) begin
         if (sample_valid && (smp16 > cur.level)) begin
            lv_new = smp16;
            if (smp16 > cur.peak) begin
               nxt.peak  = smp16;
               nxt.speed = PEAK_SPEED_INIT;
            end else begin
               do_decay = 1'b1;
            end
         end else if (tick) begin
            lv_new   = (cur.level > step) ? cur.level - step : 16'd0;
            do_decay = 1'b1;
         end
      end else if (sample_valid) begin
         lv_new = smp16;
      end
      nxt.level = lv_new;
      // a zero peak stays put along with its speed
      if (do_decay && (cur.peak != 16'd0)) begin
         nxt.peak  = (peak_dec < lv_new) ? lv_new : peak_dec;
         nxt.speed = speed_sat;
      end
   end

endmodule

// ===== sv/spectrum_level_peak_falloff.sv =====
`timescale 1ns / 1ps
// top level of the spectrum level / peak-hold tracker with band state memory
// depends on slpf_pkg and slpf_update
//
// Usage: one band item per req_ transfer (band, sample, sample_valid, tick,
// frame_end); one result per item on the rsp_ channel, in order.
// Settings are written on the csr_ port while the block is idle.
// Level, peak and peak speed of every band live in one memory word per band
// with a registered read. An item is read at its transfer into the read
// register; the update stage then writes it back and loads its result into
// the output register together, once the output register is free or being
// drained. A write-back that lands on the same band as the item
// just read is forwarded, so items may follow one another every cycle,
// sustaining one item per cycle while rsp_ready stays high.
// Reset clears the per-band valid flags at once (an unwritten band reads as
// zero) and the redraw countdown, and loads the default settings; no clearing pass.
// When the receiver stalls the result holds in the output register; the update
// stage holds behind it, and once full, req_ready drops until rsp_ready returns.
module spectrum_level_peak_falloff #(
   parameter int BANDS = 75
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [6:0]  req_band,
   input  logic [7:0]  req_sample,
   input  logic        req_sample_valid,
   input  logic        req_tick,
   input  logic        req_frame_end,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [6:0]  rsp_band_out,
   output logic [15:0] rsp_level,
   output logic [15:0] rsp_peak,
   output logic        rsp_redraw,
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_index,
   input  logic [2:0]  csr_wdata
);
   import slpf_pkg::*;

   localparam int AW = (BANDS > 1) ? $clog2(BANDS) : 1;

   // settings
   update_cfg_type cfg_ff;
   logic [1:0]     refresh_ff;

   // band state memory
   logic [STATE_W-1:0] mem [BANDS];
   logic [BANDS-1:0]   written_ff;
   logic [STATE_W-1:0] rd_data_ff;
   logic               rd_written_ff;

   // update stage
   logic        s1_vld_ff;
   logic [6:0]  s1_band_ff;
   logic [AW-1:0] s1_addr_ff;
   logic        s1_in_range_ff;
   logic [7:0]  s1_sample_ff;
   logic        s1_sample_valid_ff;
   logic        s1_tick_ff;
   logic        s1_redraw_ff;
   logic        fwd_hit_ff;
   logic [STATE_W-1:0] fwd_data_ff;

   // redraw countdown
   logic [3:0] countdown_ff;
   logic [3:0] countdown_in;
   logic       redraw_in;

   // output register
   logic        rsp_valid_ff;
   logic [6:0]  rsp_band_ff;
   logic [15:0] rsp_level_ff;
   logic [15:0] rsp_peak_ff;
   logic        rsp_redraw_ff;

   logic [7:0]     band_ext;
   logic [AW-1:0]  req_addr;
   logic           req_in_range;
   logic           accept;
   logic           s1_adv;
   logic           s1_wr;
   band_state_type cur_state;
   band_state_type nxt_state;

   assign band_ext     = {1'b0, req_band};
   assign req_addr     = band_ext[AW-1:0];
   assign req_in_range = (int'(req_band) < BANDS);

   assign s1_adv    = s1_vld_ff && (!rsp_valid_ff || rsp_ready);
   assign s1_wr     = s1_adv && s1_in_range_ff;
   assign req_ready = !s1_vld_ff || s1_adv;
   assign accept    = req_valid && req_ready;

   always_comb begin
      if (fwd_hit_ff) begin
         cur_state = band_state_type'(fwd_data_ff);
      end else if (rd_written_ff) begin
         cur_state = band_state_type'(rd_data_ff);
      end else begin
         cur_state = '0;
      end
   end

   slpf_update u_update (
      .cfg          (cfg_ff),
      .cur          (cur_state),
      .sample       (s1_sample_ff),
      .sample_valid (s1_sample_valid_ff),
      .tick         (s1_tick_ff),
      .nxt          (nxt_state)
   );

   always_comb begin
      countdown_in = countdown_ff;
      redraw_in    = 1'b0;
      if (req_tick && req_frame_end) begin
         if (countdown_ff == 4'd0) begin
            redraw_in    = 1'b1;
            countdown_in = redraw_interval(refresh_ff) - 4'd1;
         end else begin
            countdown_in = countdown_ff - 4'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rd_data_ff <= mem[req_addr];
      end
      if (s1_wr) begin
         mem[s1_addr_ff] <= nxt_state;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff       <= '{display_mode: 1'b0, level_sel: 3'd2, peak_sel: 3'd2};
         refresh_ff   <= 2'd0;
         written_ff   <= '0;
         s1_vld_ff    <= 1'b0;
         countdown_ff <= 4'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_DISPLAY_MODE:  cfg_ff.display_mode <= csr_wdata[0];
               CSR_LEVEL_FALLOFF: cfg_ff.level_sel <= csr_wdata;
               CSR_PEAK_FALLOFF:  cfg_ff.peak_sel <= csr_wdata;
               CSR_REFRESH:       refresh_ff <= csr_wdata[1:0];
               default: ;
            endcase
         end
         if (s1_wr) begin
            written_ff[s1_addr_ff] <= 1'b1;
         end
         if (accept) begin
            s1_vld_ff    <= 1'b1;
            countdown_ff <= countdown_in;
         end else if (s1_adv) begin
            s1_vld_ff <= 1'b0;
         end
         if (s1_adv) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_band_ff         <= req_band;
         s1_addr_ff         <= req_addr;
         s1_in_range_ff     <= req_in_range;
         s1_sample_ff       <= req_sample;
         s1_sample_valid_ff <= req_sample_valid;
         s1_tick_ff         <= req_tick;
         s1_redraw_ff       <= redraw_in;
         rd_written_ff      <= written_ff[req_addr];
         // write-back landing on the band being read this same edge
         fwd_hit_ff         <= s1_wr && (s1_addr_ff == req_addr);
         fwd_data_ff        <= nxt_state;
      end
      if (s1_adv) begin
         rsp_band_ff   <= s1_band_ff;
         rsp_level_ff  <= s1_in_range_ff ? nxt_state.level : 16'd0;
         rsp_peak_ff   <= s1_in_range_ff ? nxt_state.peak : 16'd0;
         rsp_redraw_ff <= s1_redraw_ff;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_band_out = rsp_band_ff;
   assign rsp_level    = rsp_level_ff;
   assign rsp_peak     = rsp_peak_ff;
   assign rsp_redraw   = rsp_redraw_ff;

   // a held result blocks the update stage and the input
   assert property (@(posedge clock) disable iff (reset)
      s1_vld_ff && rsp_valid_ff && !rsp_ready |-> !req_ready)
      else $error("input taken while update stage is blocked");

   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> s1_vld_ff)
      else $error("transfer did not reach the update stage");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (int'(rsp_band_out) >= BANDS) |-> (rsp_level == 16'd0) && (rsp_peak == 16'd0))
      else $error("out of range band reports nonzero state");

   assert property (@(posedge clock) disable iff (reset)
      s1_adv |=> rsp_valid)
      else $error("update stage advanced without loading a result");

endmodule
